// ===== hdl/tscr_pkg.sv =====
// Shared constants, codes and preset stop table for the three-stop color ramp sampler.
package tscr_pkg;

  localparam int unsigned FRACTION_BITS_DEF = 16;
  localparam int unsigned INTENSITY_W       = 18;
  localparam int unsigned CHAN_W            = 8;
  localparam int unsigned STOP_W            = 4 * CHAN_W;
  localparam int unsigned PRESET_W          = 3;
  localparam int unsigned CFG_IDX_W         = 3;
  localparam int unsigned CFG_DATA_W        = STOP_W;
  localparam int unsigned NUM_PRESETS       = 4;
  localparam int unsigned NUM_STOPS         = 3;

  typedef enum logic [PRESET_W-1:0] {
    PRESET_VIRIDIS   = 3'd0,
    PRESET_MAGMA     = 3'd1,
    PRESET_COOL_HOT  = 3'd2,
    PRESET_GRAYSCALE = 3'd3,
    PRESET_CUSTOM    = 3'd4
  } preset_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESET      = 3'd0,
    CFG_REVERSE     = 3'd1,
    CFG_CUSTOM_LOW  = 3'd2,
    CFG_CUSTOM_MID  = 3'd3,
    CFG_CUSTOM_HIGH = 3'd4
  } cfg_idx_e;

  // Stops packed r<<24 | g<<16 | b<<8 | a; columns are low, mid, high.
  localparam logic [STOP_W-1:0] RAMP_ROM [NUM_PRESETS][NUM_STOPS] = '{
    '{32'h440154FF, 32'h21918CFF, 32'hFDE725FF},
    '{32'h140E36FF, 32'hB73779FF, 32'hFCFDBFFF},
    '{32'h6496F0FF, 32'hF0B43CFF, 32'hF05050FF},
    '{32'h3C3C3CFF, 32'h8C8C8CFF, 32'hE6E6E6FF}
  };

  localparam logic [STOP_W-1:0] CUSTOM_LOW_RST  = 32'h440154FF;
  localparam logic [STOP_W-1:0] CUSTOM_MID_RST  = 32'h21918CFF;
  localparam logic [STOP_W-1:0] CUSTOM_HIGH_RST = 32'hFDE725FF;

endpackage

// ===== hdl/tscr_stream_if.sv =====
// Valid/ready stream interfaces for intensity requests and RGBA results.
interface tscr_in_if;
  import tscr_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [INTENSITY_W-1:0] intensity;

  modport source (output valid, output intensity, input ready);
  modport sink   (input valid, input intensity, output ready);
endinterface

interface tscr_out_if;
  import tscr_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic [CHAN_W-1:0] alpha;

  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  output ready);
endinterface

// ===== hdl/tscr_blend.sv =====
// One-channel linear blend between two 8-bit stops with round-half-up and clamp.
module tscr_blend #(
  parameter int unsigned FRACTION_BITS = tscr_pkg::FRACTION_BITS_DEF
) (
  input  logic [tscr_pkg::CHAN_W-1:0] a_i,
  input  logic [tscr_pkg::CHAN_W-1:0] b_i,
  input  logic [FRACTION_BITS:0]      f_i,
  output logic [tscr_pkg::CHAN_W-1:0] chan_o
);
  import tscr_pkg::*;

  // Blend is a*ONE + (b - a)*f; magnitude stays below 2^(FRACTION_BITS+9).
  localparam int unsigned VW = FRACTION_BITS + CHAN_W + 3;
  localparam int unsigned QW = VW - FRACTION_BITS;
  localparam logic [VW-1:0] HALF_V = VW'(1) << (FRACTION_BITS - 1);

  logic signed [CHAN_W:0]        diff;
  logic signed [FRACTION_BITS+1:0] f_s;
  logic signed [VW-1:0]          prod;
  logic signed [VW-1:0]          base;
  logic signed [VW-1:0]          v;
  logic signed [VW-1:0]          vr;
  logic        [QW-1:0]          q;

  always_comb begin
    diff = signed'({1'b0, b_i}) - signed'({1'b0, a_i});
    f_s  = signed'({1'b0, f_i});
    prod = VW'(diff) * VW'(f_s);
    base = signed'(VW'({a_i, {FRACTION_BITS{1'b0}}}));
    v    = base + prod;
    vr   = v + signed'(HALF_V);
    q    = vr[VW-1:FRACTION_BITS];
    if (v[VW-1]) begin
      chan_o = '0;
    end else if (|q[QW-2:CHAN_W]) begin
      chan_o = '1;
    end else begin
      chan_o = q[CHAN_W-1:0];
    end
  end

endmodule

// ===== hdl/three_stop_color_ramp_sampler_core.sv =====
// Top level: intensity to RGBA sampler on a three-stop color ramp.
//
//   channel  dir  handshake          payload
//   in_i     in   valid/ready        intensity (signed, FRACTION_BITS fraction bits)
//   out_o    out  valid/ready        red, green, blue, alpha (8 bits each)
//   cfg      in   cfg_we_i           cfg_idx_i, cfg_data_i (write only)
//
// One request per cycle unless out_o stalls; input register, then result register.
// The blend path is four parallel 9 x (FRACTION_BITS+2) multiplies between the registers.
// A stalled result holds in the result register; the input register keeps accepting
// while it is empty or the result register frees up in the same cycle.
// Reset clears valids and loads the configuration defaults; no clearing pass.
module three_stop_color_ramp_sampler_core #(
  parameter int unsigned FRACTION_BITS = tscr_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tscr_in_if.sink                        in_i,
  tscr_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [tscr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tscr_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tscr_pkg::*;

  localparam int unsigned TW = FRACTION_BITS + 1;
  localparam int unsigned CW = (FRACTION_BITS + 2 > INTENSITY_W) ? FRACTION_BITS + 2
                                                                 : INTENSITY_W;
  localparam logic [TW-1:0]        ONE   = TW'(1) << FRACTION_BITS;
  localparam logic [TW-1:0]        HALF  = TW'(1) << (FRACTION_BITS - 1);
  localparam logic signed [CW-1:0] ONE_X = signed'(CW'(1) << FRACTION_BITS);

  // Configuration registers
  logic [PRESET_W-1:0] preset_q;
  logic                rev_q;
  logic [STOP_W-1:0]   cust_lo_q;
  logic [STOP_W-1:0]   cust_mid_q;
  logic [STOP_W-1:0]   cust_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preset_q   <= PRESET_VIRIDIS;
      rev_q      <= 1'b0;
      cust_lo_q  <= CUSTOM_LOW_RST;
      cust_mid_q <= CUSTOM_MID_RST;
      cust_hi_q  <= CUSTOM_HIGH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PRESET:      preset_q   <= cfg_data_i[PRESET_W-1:0];
        CFG_REVERSE:     rev_q      <= cfg_data_i[0];
        CFG_CUSTOM_LOW:  cust_lo_q  <= cfg_data_i[STOP_W-1:0];
        CFG_CUSTOM_MID:  cust_mid_q <= cfg_data_i[STOP_W-1:0];
        CFG_CUSTOM_HIGH: cust_hi_q  <= cfg_data_i[STOP_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic s1_valid_q;
  logic out_valid_q;
  logic adv_out;
  logic in_acc;
  logic s1_move;

  assign adv_out  = !out_valid_q || out_o.ready;
  assign s1_move  = s1_valid_q && adv_out;
  assign in_i.ready = !s1_valid_q || adv_out;
  assign in_acc   = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (adv_out) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Input register
  logic signed [INTENSITY_W-1:0] s1_int_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_int_q <= in_i.intensity;
    end
  end

  // Saturate, mirror, pick segment and stops
  logic signed [CW-1:0] int_x;
  logic [TW-1:0]        t_sat;
  logic [TW-1:0]        t;
  logic [TW-1:0]        f;
  logic                 seg_hi;
  logic [STOP_W-1:0]    stop_lo;
  logic [STOP_W-1:0]    stop_mid;
  logic [STOP_W-1:0]    stop_hi;
  logic [STOP_W-1:0]    s0;
  logic [STOP_W-1:0]    s1;

  always_comb begin
    int_x = CW'(s1_int_q);
    if (int_x < 0) begin
      t_sat = '0;
    end else if (int_x > ONE_X) begin
      t_sat = ONE;
    end else begin
      t_sat = int_x[TW-1:0];
    end
    t      = rev_q ? (ONE - t_sat) : t_sat;
    seg_hi = (t >= HALF);
    f      = seg_hi ? ((t - HALF) << 1) : (t << 1);

    // Preset codes past custom fall back to the custom stops.
    if (preset_q < PRESET_CUSTOM) begin
      stop_lo  = RAMP_ROM[preset_q[1:0]][0];
      stop_mid = RAMP_ROM[preset_q[1:0]][1];
      stop_hi  = RAMP_ROM[preset_q[1:0]][2];
    end else begin
      stop_lo  = cust_lo_q;
      stop_mid = cust_mid_q;
      stop_hi  = cust_hi_q;
    end
    s0 = seg_hi ? stop_mid : stop_lo;
    s1 = seg_hi ? stop_hi  : stop_mid;
  end

  logic [CHAN_W-1:0] chan [4];

  for (genvar ch = 0; ch < 4; ch++) begin : g_chan
    tscr_blend #(
      .FRACTION_BITS(FRACTION_BITS)
    ) u_blend (
      .a_i   (s0[STOP_W-1-CHAN_W*ch -: CHAN_W]),
      .b_i   (s1[STOP_W-1-CHAN_W*ch -: CHAN_W]),
      .f_i   (f),
      .chan_o(chan[ch])
    );
  end

  // Result register
  logic [CHAN_W-1:0] red_q;
  logic [CHAN_W-1:0] green_q;
  logic [CHAN_W-1:0] blue_q;
  logic [CHAN_W-1:0] alpha_q;

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      red_q   <= chan[0];
      green_q <= chan[1];
      blue_q  <= chan[2];
      alpha_q <= chan[3];
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.red   = red_q;
  assign out_o.green = green_q;
  assign out_o.blue  = blue_q;
  assign out_o.alpha = alpha_q;

  // Checks
  a_acc_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted request did not reach the input register");

  a_s1_moves_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> out_valid_q)
    else $error("input register advanced without a result");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv_out) |=> (s1_valid_q && $stable(s1_int_q)))
    else $error("input register lost a request during a stall");

  a_ready_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s1_valid_q && out_valid_q && !out_o.ready))
    else $error("request refused while pipeline had room");

endmodule
